### hdl/ctfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctfd_pkg
// shared types and constants of the copy text field decoder
// ----------------------------------------------------------------------------
package ctfd_pkg;

   // character codes
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_NULLM = 8'h4E;  // 'N'
   localparam logic [7:0] CH_OCT0  = 8'h30;  // '0'
   localparam logic [7:0] CH_OCT7  = 8'h37;  // '7'
   localparam logic [7:0] CH_LB    = 8'h62;  // 'b'
   localparam logic [7:0] CH_LV    = 8'h76;  // 'v'
   localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
   localparam logic [7:0] CH_LN    = 8'h6E;  // 'n'
   localparam logic [7:0] CH_LT    = 8'h74;  // 't'
   localparam logic [7:0] CH_LR    = 8'h72;  // 'r'

   // decoded control bytes
   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_VT = 8'h0B;
   localparam logic [7:0] CTL_FF = 8'h0C;
   localparam logic [7:0] CTL_LF = 8'h0A;
   localparam logic [7:0] CTL_HT = 8'h09;
   localparam logic [7:0] CTL_CR = 8'h0D;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_ROW_BSL    = 3'd1;
   localparam logic [2:0] ERR_OCT_TRUNC  = 3'd2;
   localparam logic [2:0] ERR_OCT_BAD    = 3'd3;
   localparam logic [2:0] ERR_NULL_DATA  = 3'd4;
   localparam logic [2:0] ERR_DATA_NULL  = 3'd5;
   localparam logic [2:0] ERR_MAX        = 3'd5;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       row_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       field_end;
      logic       field_null;
      logic [2:0] error_code;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       escape_pending;
      logic [1:0] octal_digits_seen;
      logic [7:0] octal_accum;
      logic       field_has_data;
      logic       field_is_null;
      logic       skip_to_tab;
      logic       error_hold;
   } state_type;

   // decoder step outcome, up to two result words
   typedef struct packed {
      logic [1:0] count;
      rsp_type    rsp0;
      rsp_type    rsp1;
      state_type  nxt;
   } step_type;

endpackage

### hdl/ctfd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctfd_decode
// one-byte step of the field decoder: next state and up to two result words
// ----------------------------------------------------------------------------
module ctfd_decode (
   input  ctfd_pkg::state_type st,
   input  ctfd_pkg::req_type   req,
   output ctfd_pkg::step_type  step
);

   logic       is_oct;
   logic [2:0] digit;

   assign is_oct = (req.in_byte inside {[ctfd_pkg::CH_OCT0 : ctfd_pkg::CH_OCT7]});
   assign digit  = req.in_byte[2:0];

   always_comb begin
      ctfd_pkg::state_type nst;
      ctfd_pkg::rsp_type   prim;
      ctfd_pkg::rsp_type   sec;
      logic [2:0]          fail_code;
      logic                do_emit;
      logic                do_end;
      logic                prim_v;
      logic                sec_v;
      logic [7:0]          dv;

      nst       = st;
      fail_code = ctfd_pkg::ERR_NONE;
      do_emit   = 1'b0;
      do_end    = 1'b0;
      dv        = req.in_byte;
      prim      = '0;
      sec       = '0;
      prim_v    = 1'b0;
      sec_v     = 1'b0;

      if (st.error_hold) begin
         if (req.row_end) begin
            nst = '0;
         end
      end else begin
         if (st.octal_digits_seen != 2'd0) begin
            if (st.octal_digits_seen == 2'd1 && req.row_end) begin
               fail_code = ctfd_pkg::ERR_OCT_TRUNC;
            end else if (!is_oct) begin
               fail_code = ctfd_pkg::ERR_OCT_BAD;
            end else begin
               nst.octal_accum       = {st.octal_accum[4:0], digit};
               nst.octal_digits_seen = st.octal_digits_seen + 2'd1;
               if (st.octal_digits_seen == 2'd2) begin
                  dv                    = {st.octal_accum[4:0], digit};
                  do_emit               = 1'b1;
                  nst.octal_digits_seen = 2'd0;
                  nst.octal_accum       = 8'd0;
               end
            end
         end else if (st.escape_pending) begin
            nst.escape_pending = 1'b0;
            if (req.in_byte == ctfd_pkg::CH_NULLM) begin
               if (st.field_has_data) begin
                  fail_code = ctfd_pkg::ERR_NULL_DATA;
               end else begin
                  nst.field_is_null = 1'b1;
               end
            end else if (is_oct) begin
               if (req.row_end) begin
                  fail_code = ctfd_pkg::ERR_OCT_TRUNC;
               end else begin
                  nst.octal_accum       = {5'd0, digit};
                  nst.octal_digits_seen = 2'd1;
               end
            end else begin
               do_emit = 1'b1;
               case (req.in_byte)
                  ctfd_pkg::CH_LB: dv = ctfd_pkg::CTL_BS;
                  ctfd_pkg::CH_LV: dv = ctfd_pkg::CTL_VT;
                  ctfd_pkg::CH_LF: dv = ctfd_pkg::CTL_FF;
                  ctfd_pkg::CH_LN: dv = ctfd_pkg::CTL_LF;
                  ctfd_pkg::CH_LT: dv = ctfd_pkg::CTL_HT;
                  ctfd_pkg::CH_LR: dv = ctfd_pkg::CTL_CR;
                  default:         dv = req.in_byte;
               endcase
            end
         end else if (st.skip_to_tab) begin
            do_end = (req.in_byte == ctfd_pkg::CH_TAB);
         end else if (req.in_byte == ctfd_pkg::CH_TAB) begin
            do_end = 1'b1;
         end else if (req.in_byte == ctfd_pkg::CH_NL) begin
            nst.skip_to_tab = 1'b1;
         end else if (req.in_byte == ctfd_pkg::CH_BSL) begin
            if (req.row_end) begin
               fail_code = ctfd_pkg::ERR_ROW_BSL;
            end else begin
               nst.escape_pending = 1'b1;
            end
         end else begin
            do_emit = 1'b1;
         end

         // data into a null field is an error
         if (do_emit) begin
            if (st.field_is_null) begin
               fail_code = ctfd_pkg::ERR_DATA_NULL;
            end else begin
               prim.out_byte      = dv;
               prim.byte_valid    = 1'b1;
               prim_v             = 1'b1;
               nst.field_has_data = 1'b1;
            end
         end

         if (do_end) begin
            prim.field_end  = 1'b1;
            prim.field_null = st.field_is_null;
            prim_v          = 1'b1;
            nst             = '0;
         end

         if (fail_code != ctfd_pkg::ERR_NONE) begin
            prim            = '0;
            prim.error_code = fail_code;
            prim_v          = 1'b1;
            nst.error_hold  = 1'b1;
         end

         // row end closes the open field unless the byte failed, then everything clears
         if (req.row_end) begin
            if (fail_code == ctfd_pkg::ERR_NONE) begin
               sec.field_end  = 1'b1;
               sec.field_null = nst.field_is_null;
               sec_v          = 1'b1;
            end
            nst = '0;
         end
      end

      step.nxt = nst;
      if (prim_v) begin
         step.rsp0      = prim;
         step.rsp1      = sec;
         step.rsp0.last = !sec_v;
         step.rsp1.last = sec_v;
         step.count     = sec_v ? 2'd2 : 2'd1;
      end else begin
         step.rsp0      = sec;
         step.rsp0.last = sec_v;
         step.rsp1      = '0;
         step.count     = {1'b0, sec_v};
      end
   end

endmodule

### hdl/ctfd_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctfd_rsp_fifo
// small result queue, takes up to two words a cycle and hands out one
// ----------------------------------------------------------------------------
module ctfd_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_count,
   input  ctfd_pkg::rsp_type push_word0,
   input  ctfd_pkg::rsp_type push_word1,
   output logic              room_two,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ctfd_pkg::rsp_type rsp_data
);

   ctfd_pkg::rsp_type             mem_ff [ctfd_pkg::FIFO_DEPTH];
   logic [ctfd_pkg::PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ctfd_pkg::PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ctfd_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [ctfd_pkg::PTR_W-1:0]    wr_ptr_nxt;
   logic                          pop;

   assign pop        = rsp_valid && rsp_ready;
   assign wr_ptr_nxt = wr_ptr_ff + ctfd_pkg::PTR_W'(1);
   assign rsp_valid  = (count_ff != '0);
   assign rsp_data   = mem_ff[rd_ptr_ff];
   assign room_two   = (count_ff <= ctfd_pkg::CNT_W'(ctfd_pkg::FIFO_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + ctfd_pkg::PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + ctfd_pkg::PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + ctfd_pkg::CNT_W'(push_count) - ctfd_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_word0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_nxt] <= push_word1;
      end
   end

endmodule

### hdl/copy_text_field_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// copy_text_field_decoder
// text-format table-dump row decoder, one raw byte per word in
// ----------------------------------------------------------------------------
// Takes one raw row byte per cycle and decodes it in a single pass against
// the field state register; each byte gives zero, one or two result words
// (decoded data byte, field end with null flag, or an error code), which go
// into a four-word result queue. A byte is taken whenever the queue has room
// for two words, so the block sustains one byte per cycle as long as the
// consumer drains one word per cycle; a byte that gives two words (field end
// on the row's last byte) adds a word to the output side. A byte's first
// result word is offered the cycle after it is taken if the queue was empty.
// ----------------------------------------------------------------------------
module copy_text_field_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ctfd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ctfd_pkg::rsp_type rsp_data
);

   // field state: escape, octal progress, null and skip flags, error hold
   ctfd_pkg::state_type state_ff, state_in;
   ctfd_pkg::step_type  step;
   logic                accept;
   logic                room_two;
   logic [1:0]          push_count;

   // take a byte only while the queue can hold both words it may give
   assign req_ready  = room_two;
   assign accept     = req_valid && req_ready;
   assign push_count = accept ? step.count : 2'd0;

   // single-pass decode of the offered byte
   ctfd_decode u_decode (
      .st   (state_ff),
      .req  (req_data),
      .step (step)
   );

   // state advances only on an accepted byte
   assign state_in = accept ? step.nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // result queue parts the two handshakes
   ctfd_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_word0 (step.rsp0),
      .push_word1 (step.rsp1),
      .room_two   (room_two),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### hdl/ctfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctfd_checker
// port-level checks of the copy text field decoder
// ----------------------------------------------------------------------------
module ctfd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input ctfd_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ctfd_pkg::rsp_type rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // an error word carries nothing else
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != ctfd_pkg::ERR_NONE |->
         !rsp_data.byte_valid && !rsp_data.field_end && !rsp_data.field_null
         && rsp_data.out_byte == 8'd0 && rsp_data.error_code <= ctfd_pkg::ERR_MAX)
      else $error("malformed error word");

   // a data byte never also ends a field, a null flag only with field end
   a_kind_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.byte_valid && rsp_data.field_end)
         && (!rsp_data.field_null || rsp_data.field_end))
      else $error("result word mixes kinds");

   // a data word never ends an item's results on a row end byte
   a_data_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.row_end && !rsp_valid |=>
         rsp_valid && !rsp_data.byte_valid || !rsp_data.last || !rsp_valid
         || rsp_data.field_end || rsp_data.error_code != ctfd_pkg::ERR_NONE)
      else $error("row end closed on a data word");

endmodule

bind copy_text_field_decoder ctfd_checker u_ctfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
